### rtl/bcmp_pkg.sv
// Shared types, constants and the sequencer control store for the binomial block.
`default_nettype none

package bcmp_pkg;

  // Count width and the derived stream widths
  localparam int COUNT_BITS    = 19;
  localparam int IN_BITS       = 2 * COUNT_BITS;
  localparam int IN_DATA_BITS  = ((IN_BITS + 7) / 8) * 8;

  // Modulus and the widths that follow from it
  localparam int MOD_BITS      = 30;
  localparam int OUT_DATA_BITS = ((MOD_BITS + 7) / 8) * 8;
  localparam int PROD_BITS     = 2 * MOD_BITS;
  localparam int EXP_BITS      = 30;
  localparam int BIT_CNT_W     = $clog2(EXP_BITS + 1);

  localparam logic [MOD_BITS-1:0] PRIME_MOD  = MOD_BITS'(1000000007);
  localparam logic [EXP_BITS-1:0] FERMAT_EXP = EXP_BITS'(64'(PRIME_MOD) - 64'd2);

  // Barrett reciprocal floor(2^(2k) / p) for k = MOD_BITS
  localparam logic [MOD_BITS:0] BARRETT_MU =
    (MOD_BITS + 1)'((64'd1 << PROD_BITS) / 64'(PRIME_MOD));

  // Multiplier operation; also tags the destination register of the result
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_NUM,
    MUL_DEN,
    MUL_POW,
    MUL_SQR,
    MUL_FIN
  } mul_op_t;

  typedef struct packed {
    logic                valid;
    mul_op_t             dest;
    logic [MOD_BITS-1:0] x;
    logic [MOD_BITS-1:0] y;
  } mm_req_t;

  typedef struct packed {
    logic                valid;
    mul_op_t             dest;
    logic [MOD_BITS-1:0] value;
  } mm_rsp_t;

  // Branch conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_LOOP_DONE,
    COND_BIT_CLR,
    COND_DRAINED,
    COND_EXP_DONE,
    COND_OUT_FREE
  } cond_t;

  // Step addresses of the control program
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_NUM,
    ST_DEN,
    ST_LWAIT,
    ST_PINIT,
    ST_PBIT,
    ST_PMUL,
    ST_PSQR,
    ST_PWAIT,
    ST_PCHK,
    ST_FIN,
    ST_FWAIT,
    ST_EMIT
  } step_t;

  // One control word; action bits fire only when the condition holds
  typedef struct packed {
    mul_op_t issue;
    cond_t   cond;
    logic    load;
    logic    inc_idx;
    logic    init_pow;
    logic    inc_bit;
    logic    emit;
    step_t   next_t;
    step_t   next_f;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c.issue    = MUL_NONE;
    c.cond     = COND_ALWAYS;
    c.load     = 1'b0;
    c.inc_idx  = 1'b0;
    c.init_pow = 1'b0;
    c.inc_bit  = 1'b0;
    c.emit     = 1'b0;
    c.next_t   = ST_IDLE;
    c.next_f   = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        c.cond = COND_IN; c.load = 1'b1;
        c.next_t = ST_CHK; c.next_f = ST_IDLE;
      end
      ST_CHK: begin
        c.cond = COND_LOOP_DONE;
        c.next_t = ST_PINIT; c.next_f = ST_NUM;
      end
      ST_NUM: begin
        c.issue = MUL_NUM;
        c.next_t = ST_DEN; c.next_f = ST_DEN;
      end
      ST_DEN: begin
        c.issue = MUL_DEN; c.inc_idx = 1'b1;
        c.next_t = ST_LWAIT; c.next_f = ST_LWAIT;
      end
      ST_LWAIT: begin
        c.cond = COND_DRAINED;
        c.next_t = ST_CHK; c.next_f = ST_LWAIT;
      end
      ST_PINIT: begin
        c.init_pow = 1'b1;
        c.next_t = ST_PBIT; c.next_f = ST_PBIT;
      end
      ST_PBIT: begin
        c.cond = COND_BIT_CLR;
        c.next_t = ST_PSQR; c.next_f = ST_PMUL;
      end
      ST_PMUL: begin
        c.issue = MUL_POW;
        c.next_t = ST_PSQR; c.next_f = ST_PSQR;
      end
      ST_PSQR: begin
        c.issue = MUL_SQR; c.inc_bit = 1'b1;
        c.next_t = ST_PWAIT; c.next_f = ST_PWAIT;
      end
      ST_PWAIT: begin
        c.cond = COND_DRAINED;
        c.next_t = ST_PCHK; c.next_f = ST_PWAIT;
      end
      ST_PCHK: begin
        c.cond = COND_EXP_DONE;
        c.next_t = ST_FIN; c.next_f = ST_PBIT;
      end
      ST_FIN: begin
        c.issue = MUL_FIN;
        c.next_t = ST_FWAIT; c.next_f = ST_FWAIT;
      end
      ST_FWAIT: begin
        c.cond = COND_DRAINED;
        c.next_t = ST_EMIT; c.next_f = ST_FWAIT;
      end
      ST_EMIT: begin
        c.cond = COND_OUT_FREE; c.emit = 1'b1;
        c.next_t = ST_IDLE; c.next_f = ST_EMIT;
      end
      default: begin
        c.next_t = ST_IDLE; c.next_f = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/bcmp_modmul.sv
// Pipelined modular multiplier: product, Barrett estimate, subtract, correct.
`default_nettype none

module bcmp_modmul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bcmp_pkg::mm_req_t req,
  output bcmp_pkg::mm_rsp_t      rsp,
  output logic                   busy
);
  import bcmp_pkg::*;

  localparam int Q_BITS = PROD_BITS - MOD_BITS + 1;
  localparam int R_BITS = MOD_BITS + 2;

  localparam logic [R_BITS-1:0] P_ONE = R_BITS'(PRIME_MOD);
  localparam logic [R_BITS-1:0] P_TWO = P_ONE << 1;

  logic                       v1, v2, v3, v4, v5;
  mul_op_t                    d1, d2, d3, d4, d5;
  logic [PROD_BITS-1:0]       prod1, prod2;
  logic [2*Q_BITS-1:0]        est2;
  logic [R_BITS-1:0]          low3, qp3;
  logic [R_BITS-1:0]          rem4;
  logic [MOD_BITS-1:0]        res5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    d1 <= req.dest;
    d2 <= d1;
    d3 <= d2;
    d4 <= d3;
    d5 <= d4;
    // full product
    prod1 <= PROD_BITS'(req.x) * PROD_BITS'(req.y);
    // quotient estimate times reciprocal
    prod2 <= prod1;
    est2  <= (2*Q_BITS)'(prod1[PROD_BITS-1:MOD_BITS-1]) * (2*Q_BITS)'(BARRETT_MU);
    // estimate times modulus, low bits only; remainder is below 3p
    low3  <= prod2[R_BITS-1:0];
    qp3   <= R_BITS'(PROD_BITS'(est2[2*Q_BITS-1:MOD_BITS+1]) * PROD_BITS'(PRIME_MOD));
    rem4  <= low3 - qp3;
    // drop up to two multiples of the modulus
    if (rem4 >= P_TWO) begin
      res5 <= MOD_BITS'(rem4 - P_TWO);
    end else if (rem4 >= P_ONE) begin
      res5 <= MOD_BITS'(rem4 - P_ONE);
    end else begin
      res5 <= MOD_BITS'(rem4);
    end
  end

  assign rsp.valid = v5;
  assign rsp.dest  = d5;
  assign rsp.value = res5;
  assign busy      = v1 | v2 | v3 | v4 | v5;

endmodule

`default_nettype wire

### rtl/binomial_coefficient_mod_prime.sv
// Top level: (a+b choose a) mod 1000000007 by a microcoded multiply sequencer.
// One request at a time, taken again the cycle after the result is registered
//   when the output is free. Each batch of multiplies waits out the
//   five-stage modular multiplier before the sequencer moves on; the power
//   p-2 walks 30 exponent bits, 15 of them set.
// Reset: rst is synchronous and active high; it returns the step counter to
//   idle and empties the multiplier and the output register.
`default_nettype none

module binomial_coefficient_mod_prime (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata, from bit 0 up: count_a, count_b, zero fill
  input  wire logic [bcmp_pkg::IN_DATA_BITS-1:0]  s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata, from bit 0 up: binomial_mod, zero fill
  output logic [bcmp_pkg::OUT_DATA_BITS-1:0]      m_tdata
);
  import bcmp_pkg::*;

  // The product of a run of k consecutive integers over k! is used:
  // C(a+b, a) = prod_{i=1..s} (m+i) / s!, with m = max(a,b), s = min(a,b).
  // The numerator and denominator chains advance together, one multiply of
  // each per loop pass; then the denominator is raised to p-2.

  step_t                step, step_next;
  ctrl_t                cw;
  logic                 cond_ok;
  logic                 fire;

  logic [COUNT_BITS-1:0] cnt_a, cnt_b;
  logic [COUNT_BITS-1:0] m_cnt, s_cnt;
  logic [COUNT_BITS:0]   idx;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [MOD_BITS-1:0]   num, den, pw, base, res;
  logic [MOD_BITS-1:0]   out_value;

  mm_req_t               req;
  mm_rsp_t               rsp;
  logic                  mm_busy;

  assign cnt_a = s_tdata[COUNT_BITS-1:0];
  assign cnt_b = s_tdata[2*COUNT_BITS-1:COUNT_BITS];

  // fetch the control word for the current step
  assign cw = ucode(step);

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_IN:        cond_ok = s_tvalid;
      COND_LOOP_DONE: cond_ok = idx > {1'b0, s_cnt};
      COND_BIT_CLR:   cond_ok = ~FERMAT_EXP[bit_cnt];
      COND_DRAINED:   cond_ok = ~mm_busy;
      COND_EXP_DONE:  cond_ok = bit_cnt == BIT_CNT_W'(EXP_BITS);
      COND_OUT_FREE:  cond_ok = ~m_tvalid | m_tready;
      default:        cond_ok = 1'b0;
    endcase
    step_next = cond_ok ? cw.next_t : cw.next_f;
  end

  assign fire     = cond_ok;
  assign s_tready = step == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // operand selection for the multiplier
  always_comb begin
    req.valid = cw.issue != MUL_NONE;
    req.dest  = cw.issue;
    unique case (cw.issue)
      MUL_NUM: begin
        req.x = num;
        req.y = MOD_BITS'((COUNT_BITS + 1)'(m_cnt) + idx);
      end
      MUL_DEN: begin
        req.x = den;
        req.y = MOD_BITS'(idx);
      end
      MUL_POW: begin
        req.x = pw;
        req.y = base;
      end
      MUL_SQR: begin
        req.x = base;
        req.y = base;
      end
      MUL_FIN: begin
        req.x = num;
        req.y = pw;
      end
      default: begin
        req.x = '0;
        req.y = '0;
      end
    endcase
  end

  bcmp_modmul u_modmul (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .busy (mm_busy)
  );

  // datapath registers: load, counters, and multiplier write-back
  always_ff @(posedge clk) begin
    if (fire && cw.load) begin
      m_cnt <= (cnt_a > cnt_b) ? cnt_a : cnt_b;
      s_cnt <= (cnt_a > cnt_b) ? cnt_b : cnt_a;
      idx   <= (COUNT_BITS + 1)'(1);
      num   <= MOD_BITS'(1);
      den   <= MOD_BITS'(1);
    end
    if (fire && cw.inc_idx) begin
      idx <= idx + (COUNT_BITS + 1)'(1);
    end
    if (fire && cw.init_pow) begin
      base    <= den;
      pw      <= MOD_BITS'(1);
      bit_cnt <= '0;
    end
    if (fire && cw.inc_bit) begin
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (rsp.valid) begin
      unique case (rsp.dest)
        MUL_NUM: num  <= rsp.value;
        MUL_DEN: den  <= rsp.value;
        MUL_POW: pw   <= rsp.value;
        MUL_SQR: base <= rsp.value;
        MUL_FIN: res  <= rsp.value;
        default: ;
      endcase
    end
  end

  // output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && cw.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cw.emit) begin
      out_value <= res;
    end
  end

  assign m_tdata = OUT_DATA_BITS'(out_value);

endmodule

`default_nettype wire
